// ----- rtl/bset_pkg.sv -----
// bset_pkg: shared types and constants for the bounded unique set
// request/response payload structs, codes, controller state enum
// no dependencies
package bset_pkg;

   // storage depth and field widths
   localparam int MAX_ENTRIES = 128;
   localparam int IDX_W       = 7;
   localparam int CNT_W       = 8;
   localparam int VAL_W       = 32;

   // capacity after reset
   localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

   // request kinds
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_NOP    = 2'd3;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_DUP      = 2'd2;
   localparam logic [1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [VAL_W-1:0] value;
   } bset_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] position;
      logic [CNT_W-1:0] entry_count;
      logic             is_full;
   } bset_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } bset_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic finish;
      logic load_rsp;
   } bset_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       full;
      logic       hit;
      logic       scan_done;
   } bset_stat_type;

endpackage

// ----- rtl/bset_dp.sv -----
// bset_dp: datapath of the bounded unique set
// entry memory, occupancy and capacity registers, scan pipeline, response register
// depends on bset_pkg
module bset_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  bset_pkg::bset_req_type req_data,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata,
   input  bset_pkg::bset_cmd_type cmd,
   output bset_pkg::bset_stat_type stat,
   output bset_pkg::bset_rsp_type rsp_data
);

   logic [bset_pkg::VAL_W-1:0] entries_mem [bset_pkg::MAX_ENTRIES];

   bset_pkg::bset_req_type      req_ff;
   logic [bset_pkg::CNT_W-1:0]  occ_ff, occ_in;
   logic [bset_pkg::CNT_W-1:0]  cap_ff;
   logic [bset_pkg::CNT_W-1:0]  eff_cap;
   logic [bset_pkg::CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic [bset_pkg::VAL_W-1:0]  rd_data_ff;
   logic [bset_pkg::IDX_W-1:0]  cmp_idx_ff;
   logic [1:0]                  res_status_ff, res_status_in;
   logic [bset_pkg::IDX_W-1:0]  res_pos_ff, res_pos_in;
   bset_pkg::bset_rsp_type      rsp_ff;
   logic                        more;
   logic                        full;
   logic                        hit;
   logic                        wr_en;

   // capacity clamp and full test
   assign eff_cap = (cap_ff > bset_pkg::CNT_W'(bset_pkg::MAX_ENTRIES))
                    ? bset_pkg::CNT_W'(bset_pkg::MAX_ENTRIES) : cap_ff;
   assign full = (occ_ff >= eff_cap);

   // scan compare on the registered read
   assign more = (rd_idx_ff < occ_ff);
   assign hit  = rd_valid_ff && (rd_data_ff == req_ff.value);

   assign stat.kind      = req_ff.req_type;
   assign stat.full      = full;
   assign stat.hit       = hit;
   assign stat.scan_done = !more && !hit;

   // scan address and in-flight flag
   always_comb begin
      rd_idx_in   = rd_idx_ff;
      rd_valid_in = 1'b0;
      if (cmd.load_req) begin
         rd_idx_in = '0;
      end else if (cmd.scan_step && more) begin
         rd_idx_in   = rd_idx_ff + 1'b1;
         rd_valid_in = 1'b1;
      end
   end

   // outcome of the request and its effect on occupancy
   always_comb begin
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      occ_in        = occ_ff;
      wr_en         = 1'b0;
      if (cmd.finish) begin
         res_status_in = bset_pkg::STAT_OK;
         res_pos_in    = '0;
         case (req_ff.req_type)
            bset_pkg::REQ_APPEND: begin
               if (full) begin
                  res_status_in = bset_pkg::STAT_FULL;
               end else if (hit) begin
                  res_status_in = bset_pkg::STAT_DUP;
               end else begin
                  res_pos_in = occ_ff[bset_pkg::IDX_W-1:0];
                  occ_in     = occ_ff + 1'b1;
                  wr_en      = 1'b1;
               end
            end
            bset_pkg::REQ_LOOKUP: begin
               if (hit) begin
                  res_pos_in = cmp_idx_ff;
               end else begin
                  res_status_in = bset_pkg::STAT_NOTFOUND;
               end
            end
            bset_pkg::REQ_CLEAR: begin
               occ_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         cap_ff      <= bset_pkg::CAP_RESET;
         rd_idx_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         rd_idx_ff   <= rd_idx_in;
         rd_valid_ff <= rd_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      if (cmd.load_rsp) begin
         rsp_ff.status      <= res_status_ff;
         rsp_ff.position    <= res_pos_ff;
         rsp_ff.entry_count <= occ_ff;
         rsp_ff.is_full     <= full;
      end
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[occ_ff[bset_pkg::IDX_W-1:0]] <= req_ff.value;
      end
      rd_data_ff <= entries_mem[rd_idx_ff[bset_pkg::IDX_W-1:0]];
      cmp_idx_ff <= rd_idx_ff[bset_pkg::IDX_W-1:0];
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- rtl/bset_ctrl.sv -----
// bset_ctrl: controller of the bounded unique set
// request/response handshake and scan sequencing
// depends on bset_pkg
module bset_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bset_pkg::bset_stat_type stat,
   output bset_pkg::bset_cmd_type  cmd
);

   bset_pkg::bset_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accept;
   logic                     decided;
   logic                     slot_free;

   assign accept    = req_valid && (state_ff == bset_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // scan ends on clear, no-op, full append, a match or the last entry
   always_comb begin
      case (stat.kind)
         bset_pkg::REQ_APPEND: decided = stat.full || stat.hit || stat.scan_done;
         bset_pkg::REQ_LOOKUP: decided = stat.hit || stat.scan_done;
         default:              decided = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bset_pkg::ST_IDLE: begin
            if (accept) state_in = bset_pkg::ST_SCAN;
         end
         bset_pkg::ST_SCAN: begin
            if (decided) state_in = bset_pkg::ST_RESP;
         end
         bset_pkg::ST_RESP: begin
            if (slot_free) state_in = bset_pkg::ST_IDLE;
         end
         default: state_in = bset_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         bset_pkg::ST_IDLE: begin
            cmd.load_req = accept;
         end
         bset_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.finish    = decided;
         end
         bset_pkg::ST_RESP: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bset_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == bset_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/bounded_unique_set.sv -----
// bounded_unique_set: insertion-ordered set of unique 32-bit values
// scan: one stored entry per cycle until a match or the last entry; clear, no-op and
//   full append end the scan at once; the response is loaded once the output slot is free
// one request at a time: the next is accepted only after the last response is loaded
// reset: synchronous; empties the set, capacity 128, entry memory left unwritten
// depends on bset_pkg, bset_ctrl, bset_dp
module bounded_unique_set (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bset_pkg::bset_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bset_pkg::bset_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata
);

   bset_pkg::bset_cmd_type  cmd;
   bset_pkg::bset_stat_type stat;

   bset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bset_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

   // one request at a time: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // count never exceeds the storage depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 8'(bset_pkg::MAX_ENTRIES))
      else $error("entry count above depth");

   // refused or missing requests report position zero
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == bset_pkg::STAT_DUP ||
                    rsp_data.status == bset_pkg::STAT_NOTFOUND ||
                    rsp_data.status == bset_pkg::STAT_FULL)
      |-> rsp_data.position == '0)
      else $error("nonzero position on refused request");

endmodule

// ----- tb/tb_bounded_unique_set.sv -----
// tb_bounded_unique_set: self-checking testbench for the bounded unique set
// keeps a shadow copy of the set, checks every response field in order
// depends on bset_pkg and bounded_unique_set
`timescale 1ns / 100ps

module tb_bounded_unique_set;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = bset_pkg::MAX_ENTRIES + 12;
   localparam int STALL_PCT = 31;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   bset_pkg::bset_req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   bset_pkg::bset_rsp_type rsp_data;
   logic                   csr_we;
   logic [7:0]             csr_wdata;

   // shadow copy of the set contents and its capacity register
   logic [bset_pkg::VAL_W-1:0] shadow_vals [bset_pkg::MAX_ENTRIES];
   int                         shadow_count;
   logic [bset_pkg::CNT_W-1:0] shadow_cap;

   // answers owed by the block, oldest first
   bset_pkg::bset_rsp_type answers_due [$];

   bit  req_gaps_on;
   bit  rsp_stalls_on;
   int  fail_count = 0;
   int  requests_sent;
   int  answers_checked = 0;
   int  full_seen = 0;
   int  dup_seen = 0;
   int  miss_seen = 0;
   int  cycle_count = 0;
   bset_pkg::bset_rsp_type want;

   bounded_unique_set u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // apply one request to the shadow set and return the answer it owes
   function automatic bset_pkg::bset_rsp_type shadow_set_apply(bset_pkg::bset_req_type rq);
      bset_pkg::bset_rsp_type ans;
      int lim;
      int hit_at;
      lim = (shadow_cap > bset_pkg::MAX_ENTRIES) ? bset_pkg::MAX_ENTRIES : int'(shadow_cap);
      hit_at = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit_at < 0 && shadow_vals[i] == rq.value) hit_at = i;
      end
      ans = '0;
      ans.status = bset_pkg::STAT_OK;
      case (rq.req_type)
         bset_pkg::REQ_APPEND: begin
            if (shadow_count >= lim) begin
               ans.status = bset_pkg::STAT_FULL;
            end else if (hit_at >= 0) begin
               ans.status = bset_pkg::STAT_DUP;
            end else begin
               ans.position = bset_pkg::IDX_W'(shadow_count);
               shadow_vals[shadow_count] = rq.value;
               shadow_count++;
            end
         end
         bset_pkg::REQ_LOOKUP: begin
            if (hit_at >= 0) ans.position = bset_pkg::IDX_W'(hit_at);
            else ans.status = bset_pkg::STAT_NOTFOUND;
         end
         bset_pkg::REQ_CLEAR: begin
            shadow_count = 0;
         end
         default: ;
      endcase
      ans.entry_count = bset_pkg::CNT_W'(shadow_count);
      ans.is_full = (shadow_count >= lim);
      return ans;
   endfunction

   function automatic void check_field(string fname, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
         fail_count++;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: response with nothing outstanding, actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            want = answers_due.pop_front();
            check_field("status", 8'(want.status), 8'(rsp_data.status));
            check_field("position", 8'(want.position), 8'(rsp_data.position));
            check_field("entry_count", want.entry_count, rsp_data.entry_count);
            check_field("is_full", 8'(want.is_full), 8'(rsp_data.is_full));
            answers_checked++;
            if (rsp_data.status == bset_pkg::STAT_FULL) full_seen++;
            if (rsp_data.status == bset_pkg::STAT_DUP) dup_seen++;
            if (rsp_data.status == bset_pkg::STAT_NOTFOUND) miss_seen++;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= !(rsp_stalls_on && $urandom_range(0, 99) < STALL_PCT);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit reached with %0d responses outstanding", $time,
                  answers_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   // send one request; valid stays high afterwards until the next gap or drain
   task automatic send_request(input logic [1:0] kind, input logic [bset_pkg::VAL_W-1:0] val);
      bset_pkg::bset_req_type rq;
      rq.req_type = kind;
      rq.value = val;
      if (req_gaps_on) begin
         while ($urandom_range(0, 99) < STALL_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      answers_due.push_back(shadow_set_apply(rq));
      requests_sent++;
   endtask

   // hold off the sender until every owed answer has come back
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   task automatic set_capacity(input logic [7:0] cap);
      wait_for_answers();
      csr_we <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_cap = cap;
   endtask

   // value extremes, every request kind, duplicates, misses
   task automatic test_directed_basics();
      send_request(bset_pkg::REQ_LOOKUP, 32'h0000_0005);
      send_request(bset_pkg::REQ_APPEND, 32'h8000_0000);
      send_request(bset_pkg::REQ_APPEND, 32'h7FFF_FFFF);
      send_request(bset_pkg::REQ_APPEND, 32'hFFFF_FFFF);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_0000);
      send_request(bset_pkg::REQ_APPEND, 32'h7FFF_FFFF);
      send_request(bset_pkg::REQ_LOOKUP, 32'h8000_0000);
      send_request(bset_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
      send_request(bset_pkg::REQ_LOOKUP, 32'h1234_5678);
      send_request(bset_pkg::REQ_NOP, 32'hA5A5_A5A5);
      send_request(bset_pkg::REQ_CLEAR, 32'h5A5A_5A5A);
      send_request(bset_pkg::REQ_LOOKUP, 32'h0000_0000);
      send_request(bset_pkg::REQ_APPEND, 32'hFFFF_FFFF);
   endtask

   // zero capacity, full set, full plus duplicate, capacity below count
   task automatic test_capacity_limits();
      set_capacity(8'd0);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_0011);
      send_request(bset_pkg::REQ_LOOKUP, 32'hFFFF_FFFF);
      send_request(bset_pkg::REQ_CLEAR, 32'h0);
      set_capacity(8'd3);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_00A1);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_00A2);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_00A3);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_00A4);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_00A1);
      set_capacity(8'd1);
      send_request(bset_pkg::REQ_LOOKUP, 32'h0000_00A3);
      send_request(bset_pkg::REQ_APPEND, 32'h0000_00B0);
      send_request(bset_pkg::REQ_CLEAR, 32'h0);
   endtask

   // fill every slot with capacity above the depth, then shrink below count
   task automatic test_fill_to_limit();
      logic [bset_pkg::VAL_W-1:0] first_val;
      logic [bset_pkg::VAL_W-1:0] last_val;
      logic [bset_pkg::VAL_W-1:0] v;
      first_val = '0;
      last_val = '0;
      set_capacity(8'd255);
      send_request(bset_pkg::REQ_CLEAR, $urandom());
      for (int i = 0; i < bset_pkg::MAX_ENTRIES; i++) begin
         v = ($urandom() & 32'hFFFF_FF80) | bset_pkg::VAL_W'(i);
         if (i == 0) first_val = v;
         last_val = v;
         send_request(bset_pkg::REQ_APPEND, v);
      end
      send_request(bset_pkg::REQ_APPEND, 32'h0000_0001);
      send_request(bset_pkg::REQ_LOOKUP, last_val);
      send_request(bset_pkg::REQ_LOOKUP, first_val);
      set_capacity(8'd100);
      send_request(bset_pkg::REQ_APPEND, first_val);
      send_request(bset_pkg::REQ_LOOKUP, last_val);
      send_request(bset_pkg::REQ_CLEAR, 32'h0);
   endtask

   // random traffic: mostly appends and lookups, some hits on stored values
   task automatic test_random_mix(input int n_items, input logic [7:0] cap, input bit quiet);
      int roll;
      logic [bset_pkg::VAL_W-1:0] v;
      set_capacity(cap);
      req_gaps_on = !quiet;
      rsp_stalls_on = !quiet;
      for (int n = 0; n < n_items; n++) begin
         if ($urandom_range(0, 99) < 3) wait_for_answers();
         roll = $urandom_range(0, 99);
         v = $urandom();
         if (shadow_count > 0 && (roll < 12 || (roll >= 45 && roll < 70))) begin
            v = shadow_vals[$urandom_range(0, shadow_count - 1)];
         end
         if (roll < 60) send_request(bset_pkg::REQ_APPEND, v);
         else if (roll < 92) send_request(bset_pkg::REQ_LOOKUP, v);
         else if (roll < 96) send_request(bset_pkg::REQ_CLEAR, v);
         else send_request(bset_pkg::REQ_NOP, v);
      end
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      requests_sent = 0;
      shadow_count = 0;
      shadow_cap = bset_pkg::CAP_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_basics();
      test_capacity_limits();
      test_fill_to_limit();
      test_random_mix(90, 8'd128, 1'b0);
      test_random_mix(90, 8'd255, 1'b1);
      test_random_mix(80, 8'($urandom_range(1, 127)), 1'b0);
      test_random_mix(30, 8'd0, 1'b0);
      test_random_mix(70, 8'd6, 1'b0);
      test_random_mix(80, 8'($urandom_range(0, 255)), 1'b0);

      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests over capacities zero to 255 with random stalls",
               requests_sent);
      $display("checked %0d responses: %0d full, %0d duplicate, %0d not found",
               answers_checked, full_seen, dup_seen, miss_seen);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
